FILE: rtl/core/omre_pkg.sv
// Shared types and constants for the ordered multiset rank engine.
package omre_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CountWidth  = 16;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned ModeWidth   = 3;

  localparam logic [CountWidth-1:0] CountLimit = 16'hFFFF;
  localparam logic signed [ValueWidth-1:0] IntMin = 32'sh8000_0000;
  localparam logic signed [ValueWidth-1:0] IntMax = 32'sh7FFF_FFFF;

  typedef enum logic [ModeWidth-1:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_RANK   = 3'd2,
    MODE_KTH    = 3'd3,
    MODE_PRED   = 3'd4,
    MODE_SUCC   = 3'd5,
    MODE_RSVD6  = 3'd6,
    MODE_RSVD7  = 3'd7
  } mode_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK           = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_FULL         = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_WRITE,
    S_DONE
  } state_e;

endpackage

FILE: rtl/core/ordered_multiset_rank_engine.sv
// Top level of the ordered multiset rank engine: entry memory and sequencer.
// Rejected kth requests and unused modes go straight to the result; queries scan the stored
// entries, and an update that adds or removes a distinct value also shifts entries.
// One item at a time: the next transfer is taken the cycle after the result is registered,
// and a stalled result holds the engine in its done state.
// Reset clears the entry count and item total; the memory itself is not cleared.
module ordered_multiset_rank_engine
  import omre_pkg::*;
#(
  parameter int unsigned DISTINCT_CAPACITY = 1024,
  parameter longint unsigned MAX_ITEMS = 65535
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ModeWidth-1:0]          mode_i,
  input  logic signed [ValueWidth-1:0]  operand_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ValueWidth-1:0]  answer_o,
  output logic [StatusWidth-1:0]        status_o
);

  localparam int unsigned AddrWidth = (DISTINCT_CAPACITY > 1) ? $clog2(DISTINCT_CAPACITY) : 1;
  localparam int unsigned UsedWidth = $clog2(DISTINCT_CAPACITY + 1);
  localparam logic [UsedWidth-1:0] CapUsed = UsedWidth'(DISTINCT_CAPACITY);
  localparam logic [CountWidth:0] ItemLimit =
    (MAX_ITEMS < 65535) ? (CountWidth+1)'(MAX_ITEMS) : (CountWidth+1)'(65535);

  logic [ValueWidth+CountWidth-1:0] mem_q [DISTINCT_CAPACITY];
  logic [ValueWidth+CountWidth-1:0] rdata_q, wdata;
  logic [AddrWidth-1:0] raddr, waddr;
  logic rd_en, wr_en;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  state_e state_q, state_d;
  mode_e mode_q;
  logic signed [ValueWidth-1:0] opnd_q;
  logic [UsedWidth-1:0] used_q, used_d, idx_q, idx_d, pos_q, pos_d;
  logic [CountWidth-1:0] total_q, total_d;
  logic [ValueWidth:0] acc_q, acc_d;
  logic signed [ValueWidth-1:0] prev_q, prev_d, ans_q, ans_d;
  logic [StatusWidth-1:0] st_q, st_d;
  logic found_q, found_d, rvld_q, rvld_d;
  logic out_valid_q, out_valid_d;
  logic signed [ValueWidth-1:0] ans_out_q;
  logic [StatusWidth-1:0] st_out_q;
  logic [CountWidth-1:0] wcount_q, wcount_d;

  logic signed [ValueWidth-1:0] rv;
  logic [CountWidth-1:0] rc;
  logic accept, out_free;
  assign rv = rdata_q[ValueWidth+CountWidth-1:CountWidth];
  assign rc = rdata_q[CountWidth-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      rvld_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      rvld_q      <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(mode_i);
      opnd_q <= operand_i;
    end
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    acc_q    <= acc_d;
    prev_q   <= prev_d;
    ans_q    <= ans_d;
    st_q     <= st_d;
    found_q  <= found_d;
    wcount_q <= wcount_d;
    if (state_q == S_DONE && out_free) begin
      ans_out_q <= ans_q;
      st_out_q  <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = ans_out_q;
  assign status_o    = st_out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_DONE && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  // Scan reads entry idx each cycle; data for entry idx-1 arrives when rvld_q.
  always_comb begin
    logic [CountWidth:0] tot_ext;
    logic scan_stop;
    logic [UsedWidth-1:0] cur;
    logic [UsedWidth-1:0] up_dst;
    logic [UsedWidth-1:0] dn_dst;
    tot_ext   = {1'b0, total_q};
    scan_stop = 1'b0;
    cur       = idx_q - UsedWidth'(1);
    up_dst    = idx_q + UsedWidth'(1);
    dn_dst    = idx_q - UsedWidth'(2);
    state_d  = state_q;
    used_d   = used_q;
    total_d  = total_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    prev_d   = prev_q;
    ans_d    = ans_q;
    st_d     = st_q;
    found_d  = found_q;
    wcount_d = wcount_q;
    rvld_d   = 1'b0;
    rd_en    = 1'b0;
    raddr    = '0;
    wr_en    = 1'b0;
    waddr    = '0;
    wdata    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          pos_d   = used_q;
          acc_d   = (mode_i == MODE_KTH) ? {1'b0, operand_i} : '0;
          prev_d  = IntMin;
          found_d = 1'b0;
          ans_d   = '0;
          st_d    = ST_OK;
          state_d = S_SCAN;
          if (mode_i == MODE_SUCC) begin
            ans_d = IntMax;
          end
          if (mode_i == MODE_KTH &&
              (operand_i < 1 || $signed({1'b0, operand_i}) > $signed({16'd0, tot_ext}))) begin
            st_d    = ST_OUT_OF_RANGE;
            state_d = S_DONE;
          end
          if (mode_i == MODE_RSVD6 || mode_i == MODE_RSVD7) begin
            st_d    = ST_OUT_OF_RANGE;
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (rvld_q) begin
          case (mode_q)
            MODE_KTH: begin
              if (acc_q <= {17'd0, rc}) begin
                ans_d = rv; scan_stop = 1'b1;
              end else begin
                acc_d = acc_q - {17'd0, rc};
              end
            end
            MODE_SUCC: begin
              if (rv > opnd_q) begin
                ans_d = rv; scan_stop = 1'b1;
              end
            end
            default: begin
              if (rv >= opnd_q) begin
                scan_stop = 1'b1;
                pos_d     = cur;
                found_d   = (rv == opnd_q);
                wcount_d  = rc;
              end else begin
                prev_d = rv;
                acc_d  = acc_q + {17'd0, rc};
              end
            end
          endcase
        end
        if (!scan_stop && idx_q < used_q) begin
          rd_en  = 1'b1;
          raddr  = idx_q[AddrWidth-1:0];
          rvld_d = 1'b1;
          idx_d  = idx_q + UsedWidth'(1);
        end else begin
          state_d = S_DONE;
          case (mode_q)
            MODE_RANK: ans_d = acc_d[ValueWidth-1:0] + 32'sd1;
            MODE_PRED: ans_d = prev_d;
            MODE_INSERT: begin
              if ({1'b0, total_q} >= ItemLimit) begin
                st_d = ST_FULL;
              end else if (found_d) begin
                if (wcount_d >= CountLimit) begin
                  st_d = ST_FULL;
                end else begin
                  wcount_d = wcount_d + CountWidth'(1);
                  state_d  = S_WRITE;
                end
              end else if (used_q >= CapUsed) begin
                st_d = ST_FULL;
              end else begin
                wcount_d = CountWidth'(1);
                idx_d    = used_q;
                state_d  = S_SHIFT_UP;
              end
            end
            MODE_DELETE: begin
              if (!found_d) begin
                st_d = ST_NOT_FOUND;
              end else if (wcount_d > CountWidth'(1)) begin
                wcount_d = wcount_d - CountWidth'(1);
                state_d  = S_WRITE;
              end else begin
                idx_d   = pos_d + UsedWidth'(1);
                state_d = S_SHIFT_DN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT_UP: begin
        // Move entry idx into idx+1 while pipelining the read of idx-1.
        if (rvld_q) begin
          wr_en = 1'b1;
          waddr = up_dst[AddrWidth-1:0];
          wdata = rdata_q;
        end
        if (idx_q > pos_q) begin
          rd_en  = 1'b1;
          raddr  = cur[AddrWidth-1:0];
          rvld_d = 1'b1;
          idx_d  = cur;
          if (rvld_q) begin
            idx_d = cur;
          end
        end else if (!rvld_q) begin
          state_d = S_WRITE;
        end
        if (rvld_q && !(idx_q > pos_q)) begin
          state_d = S_WRITE;
        end
      end
      S_SHIFT_DN: begin
        if (rvld_q) begin
          wr_en = 1'b1;
          waddr = dn_dst[AddrWidth-1:0];
          wdata = rdata_q;
        end
        if (idx_q < used_q) begin
          rd_en  = 1'b1;
          raddr  = idx_q[AddrWidth-1:0];
          rvld_d = 1'b1;
          idx_d  = idx_q + UsedWidth'(1);
        end else if (!rvld_q || idx_q == used_q) begin
          used_d  = used_q - UsedWidth'(1);
          total_d = total_q - CountWidth'(1);
          state_d = S_DONE;
        end
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        waddr   = pos_q[AddrWidth-1:0];
        wdata   = {opnd_q, wcount_q};
        state_d = S_DONE;
        if (mode_q == MODE_INSERT) begin
          total_d = total_q + CountWidth'(1);
          if (wcount_q == CountWidth'(1)) begin
            used_d = used_q + UsedWidth'(1);
          end
        end else begin
          total_d = total_q - CountWidth'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CapUsed) else $error("entry count above capacity");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("input open while busy");
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN || state_q == S_DONE)) else $error("bad start");
  a_used_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(used_q) <= 32'(total_q))) else $error("more entries than items");
`endif

endmodule

FILE: verif/testbench.sv
// Testbench for the ordered multiset rank engine: directed and random operations checked
// against a behavioral model of the sorted store.
`timescale 1ns / 100ps

module testbench;
  import omre_pkg::*;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [ModeWidth-1:0]         mode_i;
  logic signed [ValueWidth-1:0] operand_i;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [ValueWidth-1:0] answer_o;
  logic [StatusWidth-1:0]       status_o;

  ordered_multiset_rank_engine DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .mode_i(mode_i), .operand_i(operand_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .answer_o(answer_o), .status_o(status_o)
  );

  localparam int unsigned Capacity = 1024;
  localparam longint CycleLimit = 64'd12_000_000;

  typedef struct packed {
    logic signed [ValueWidth-1:0] answer;
    status_e                      status;
  } outcome_t;

  logic signed [ValueWidth-1:0] store_vals[Capacity];
  int unsigned                  store_cnts[Capacity];
  int unsigned                  store_used;
  int unsigned                  store_total;

  outcome_t pending_q[$];
  int unsigned mismatch_count = 0;
  longint      cycle_count = 0;
  bit          hold_off;
  int unsigned hold_cycles;
  event        hold_start;
  int          burst_left;
  logic signed [ValueWidth-1:0] pool[16];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned lower_slot(logic signed [ValueWidth-1:0] v);
    int unsigned i;
    i = 0;
    while (i < store_used && store_vals[i] < v) i++;
    return i;
  endfunction

  function automatic outcome_t predict_outcome(mode_e m, logic signed [ValueWidth-1:0] v);
    outcome_t    r;
    int unsigned pos;
    longint      k;
    longint      smaller;
    r.answer = '0;
    r.status = ST_OK;
    pos = lower_slot(v);
    case (m)
      MODE_INSERT: begin
        if (store_total >= 65535) r.status = ST_FULL;
        else if (pos < store_used && store_vals[pos] == v) begin
          if (store_cnts[pos] >= CountLimit) r.status = ST_FULL;
          else begin
            store_cnts[pos]++;
            store_total++;
          end
        end else if (store_used >= Capacity) r.status = ST_FULL;
        else begin
          for (int unsigned i = store_used; i > pos; i--) begin
            store_vals[i] = store_vals[i-1];
            store_cnts[i] = store_cnts[i-1];
          end
          store_vals[pos] = v;
          store_cnts[pos] = 1;
          store_used++;
          store_total++;
        end
      end
      MODE_DELETE: begin
        if (pos >= store_used || store_vals[pos] != v) r.status = ST_NOT_FOUND;
        else begin
          store_total--;
          if (store_cnts[pos] > 1) store_cnts[pos]--;
          else begin
            for (int unsigned i = pos; i + 1 < store_used; i++) begin
              store_vals[i] = store_vals[i+1];
              store_cnts[i] = store_cnts[i+1];
            end
            store_used--;
          end
        end
      end
      MODE_RANK: begin
        smaller = 0;
        for (int unsigned i = 0; i < pos; i++) smaller += store_cnts[i];
        r.answer = ValueWidth'(smaller + 1);
      end
      MODE_KTH: begin
        if (v < 1 || longint'(v) > longint'(store_total)) r.status = ST_OUT_OF_RANGE;
        else begin
          k = longint'(v);
          for (int unsigned i = 0; i < store_used; i++) begin
            if (k <= store_cnts[i]) begin
              r.answer = store_vals[i];
              break;
            end
            k -= store_cnts[i];
          end
        end
      end
      MODE_PRED: r.answer = (pos > 0) ? store_vals[pos-1] : IntMin;
      MODE_SUCC: begin
        if (pos < store_used && store_vals[pos] == v) pos++;
        r.answer = (pos < store_used) ? store_vals[pos] : IntMax;
      end
      default: r.status = ST_OUT_OF_RANGE;
    endcase
    return r;
  endfunction

  task automatic send_operation(mode_e m, logic signed [ValueWidth-1:0] v);
    int unsigned gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i     <= m;
    operand_i  <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_q.push_back(predict_outcome(m, v));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      default: return pool[$urandom_range(0, 15)];
    endcase
  endfunction

  task automatic test_extremes();
    send_operation(MODE_RANK, IntMin);
    send_operation(MODE_PRED, 32'sd5);
    send_operation(MODE_SUCC, 32'sd5);
    send_operation(MODE_KTH, 32'sd1);
    send_operation(MODE_DELETE, 32'sd7);
    send_operation(MODE_INSERT, IntMin);
    send_operation(MODE_INSERT, IntMax);
    send_operation(MODE_INSERT, 32'sd0);
    send_operation(MODE_INSERT, 32'sd0);
    send_operation(MODE_INSERT, -32'sd1);
    send_operation(MODE_RANK, 32'sd0);
    send_operation(MODE_RANK, 32'sd1);
    send_operation(MODE_RANK, IntMax);
    send_operation(MODE_KTH, 32'sd0);
    send_operation(MODE_KTH, 32'sd5);
    send_operation(MODE_KTH, 32'sd6);
    send_operation(MODE_KTH, IntMin);
    send_operation(MODE_PRED, IntMin);
    send_operation(MODE_SUCC, IntMax);
    send_operation(MODE_PRED, 32'sd0);
    send_operation(MODE_SUCC, 32'sd0);
    send_operation(MODE_RSVD6, -32'sd1);
    send_operation(MODE_RSVD7, 32'sd3);
    send_operation(MODE_DELETE, 32'sd0);
    send_operation(MODE_DELETE, IntMax);
  endtask

  task automatic test_random_mix(int n);
    mode_e m;
    logic signed [ValueWidth-1:0] v;
    for (int i = 0; i < n; i++) begin
      m = mode_e'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) m = MODE_INSERT;
      v = pick_value();
      if (m == MODE_KTH)
        v = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, store_total + 1);
      send_operation(m, v);
    end
  endtask

  task automatic test_backpressure();
    -> hold_start;
    for (int i = 0; i < 20; i++) send_operation(MODE_INSERT, pick_value());
    in_valid_i <= 1'b0;
    wait (!hold_off);
    drain_results();
  endtask

  task automatic test_fill_distinct();
    for (int i = 0; i < 130; i++)
      send_operation(MODE_INSERT, $urandom);
    test_random_mix(60);
    drain_results();
    for (int i = 0; i < 40; i++)
      send_operation(MODE_DELETE, store_vals[$urandom_range(0, store_used - 1)]);
  endtask

  initial begin
    hold_off = 1'b0;
    hold_cycles = 0;
    forever begin
      @(hold_start);
      hold_off = 1'b1;
      for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(posedge clk_i);
      hold_off = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (cycle_count[9:8] == 2'b01) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transfer: answer %0d status %0d", answer_o, status_o);
      end else begin
        want = pending_q.pop_front();
        if (want.answer !== answer_o || want.status !== status_o) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("got answer %0d status %0d, wanted answer %0d status %0d",
                     answer_o, status_o, want.answer, want.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("ordered_multiset_rank_engine: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = '0;
    operand_i = '0;
    burst_left = 0;
    store_used = 0;
    store_total = 0;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = IntMin;
    pool[1] = IntMax;
    pool[2] = 32'sd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random_mix(150);
    test_backpressure();
    test_random_mix(100);
    test_fill_distinct();
    test_random_mix(60);
    drain_results();
    repeat (2 * Capacity + 20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_q.size() == 0) begin
      $display("ordered_multiset_rank_engine: match");
    end else begin
      $display("ordered_multiset_rank_engine: mismatch");
    end
    $finish;
  end

endmodule
